### src/pfa_pkg.sv
package pfa_pkg;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_e;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned CountWidth = 17;

endpackage

### src/pfa_ram.sv
module pfa_ram
  import pfa_pkg::*;
#(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/page_frame_allocator.sv
// Page frame allocator with a used bit per frame and a stack of free frame numbers.
// Input channel: in_valid_i / in_stall_o carry one request word: req_type_i selects
// allocate or free, and free_addr_i gives the byte address of the frame to free.
// Output channel: out_valid_o / out_stall_i carry one result word per request:
// status_o, alloc_addr_o and free_count_o, the number of free frames afterwards.
// A request is handled in order: the bitmap and stack memories are read as it is
// accepted, then the execute state updates them and loads the output register, so a
// new request is accepted only after the previous one leaves the execute state.
// The output register lets the next request be accepted while a result still waits;
// a request whose result finds the output register still full waits until it drains.
// After reset the block marks every frame used by sweeping the bitmap through all
// NUM_FRAMES frames, one frame per cycle; in_stall_o stays high during the sweep.
// The free stack starts empty, so software frees each usable frame once to fill it.
// PAGE_BYTES must be a power of two; the low address bits below it are ignored.
// A free of an already free frame or of a frame beyond NUM_FRAMES changes nothing.
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 65536,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [AddrWidth-1:0]  free_addr_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [AddrWidth-1:0]  alloc_addr_o,
  output logic [CountWidth-1:0] free_count_o
);

  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned DW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam logic [AddrWidth:0] NumFramesW = (AddrWidth + 1)'(NUM_FRAMES);

  state_e state_q, state_d;
  logic [FW-1:0] clr_q, clr_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [DW-1:0] depth_m1;
  logic          out_valid_q, out_valid_d;
  status_e       status_q;
  logic [AddrWidth-1:0]  alloc_q;
  logic [CountWidth-1:0] count_q;

  logic          req_q;
  logic [FW-1:0] fidx_q;
  logic          range_q;

  logic                 in_accept;
  logic                 exec_go;
  logic [AddrWidth-1:0] fnum;
  logic                 in_range;

  logic          map_we, map_wdata, map_rdata;
  logic [FW-1:0] map_waddr;
  logic          stk_we;
  logic [FW-1:0] stk_waddr, stk_wdata, stk_rdata;

  status_e              res_status;
  logic [AddrWidth-1:0] res_addr;
  logic [63:0]          addr_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign fnum = free_addr_i >> PW;
  assign in_range = {1'b0, fnum} < NumFramesW;
  assign depth_m1 = depth_q - DW'(1);
  assign addr_ext = 64'({stk_rdata, {PW{1'b0}}});

  pfa_ram #(
    .Width(1),
    .Depth(NUM_FRAMES)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .re_i   (in_accept),
    .raddr_i(fnum[FW-1:0]),
    .rdata_o(map_rdata)
  );

  pfa_ram #(
    .Width(FW),
    .Depth(NUM_FRAMES)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (in_accept),
    .raddr_i(depth_m1[FW-1:0]),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + FW'(1);
        if (clr_q == FW'(NUM_FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    map_we = 1'b0;
    map_waddr = clr_q;
    map_wdata = 1'b1;
    stk_we = 1'b0;
    stk_waddr = depth_q[FW-1:0];
    stk_wdata = fidx_q;
    depth_d = depth_q;
    res_status = ST_OK;
    res_addr = '0;
    case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
      end
      S_EXEC: begin
        if (req_q == REQ_ALLOC) begin
          if (depth_q == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_addr = addr_ext[AddrWidth-1:0];
            map_we = exec_go;
            map_waddr = stk_rdata;
            map_wdata = 1'b1;
            if (exec_go) begin
              depth_d = depth_m1;
            end
          end
        end else if (range_q) begin
          res_status = ST_RANGE;
        end else if (!map_rdata) begin
          res_status = ST_ALREADY_FREE;
        end else if (depth_q < DW'(NUM_FRAMES)) begin
          map_we = exec_go;
          map_waddr = fidx_q;
          map_wdata = 1'b0;
          stk_we = exec_go;
          if (exec_go) begin
            depth_d = depth_q + DW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      depth_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      depth_q <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_type_i;
      fidx_q <= fnum[FW-1:0];
      range_q <= !in_range;
    end
    if (exec_go) begin
      status_q <= res_status;
      alloc_q <= res_addr;
      count_q <= CountWidth'(depth_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign alloc_addr_o = alloc_q;
  assign free_count_o = count_q;

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(NUM_FRAMES))
    else $error("free stack depth exceeds frame count");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_valid_o && (free_count_o == CountWidth'(depth_q)))
    else $error("reported free count differs from stack depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC) && in_stall_o)
    else $error("accepted word did not enter execution");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!map_we && !stk_we && (depth_d == depth_q)))
    else $error("memory written while idle");
`endif

endmodule

### bench/page_frame_allocator_tb.sv
`timescale 1ns / 100ps

module page_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int unsigned NumFrames   = 65536;
  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned FrameWidth  = $clog2(NumFrames);
  localparam int unsigned NumDirected = 17;
  localparam int unsigned LongHold    = 400;

  typedef struct {
    status_e               status;
    logic [AddrWidth-1:0]  addr;
    logic [CountWidth-1:0] count;
  } frame_result_t;

  typedef struct {
    req_e                 req;
    logic [AddrWidth-1:0] addr;
    bit                   typed;
    frame_result_t        result;
  } stim_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  req_e                  req_type   = REQ_ALLOC;
  logic [AddrWidth-1:0]  free_addr  = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [1:0]            status;
  logic [AddrWidth-1:0]  alloc_addr;
  logic [CountWidth-1:0] free_count;

  bit                    frame_used [NumFrames];
  logic [FrameWidth-1:0] free_list [NumFrames];
  logic [CountWidth-1:0] stack_depth;
  logic [FrameWidth-1:0] held_frames [$];
  frame_result_t         pending_results [$];
  frame_result_t         no_result = '{ST_OK, '0, '0};

  int unsigned mismatch_count = 0;
  bit          sender_quiet   = 1'b0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned stall_left     = 0;
  int unsigned open_left      = 0;

  // Expected results are typed in only where they follow directly from reset.
  stim_row_t directed_rows [NumDirected] = '{
    '{REQ_ALLOC, 32'h0000_0000, 1'b1, '{ST_EMPTY,        32'h0000_0000, 17'd0}},
    '{REQ_FREE,  32'hFFFF_FFFF, 1'b1, '{ST_RANGE,        32'h0000_0000, 17'd0}},
    '{REQ_FREE,  32'h1000_0000, 1'b1, '{ST_RANGE,        32'h0000_0000, 17'd0}},
    '{REQ_FREE,  32'h0000_0000, 1'b1, '{ST_OK,           32'h0000_0000, 17'd1}},
    '{REQ_FREE,  32'h0000_0FFF, 1'b1, '{ST_ALREADY_FREE, 32'h0000_0000, 17'd1}},
    '{REQ_FREE,  32'h0FFF_FFFF, 1'b1, '{ST_OK,           32'h0000_0000, 17'd2}},
    '{REQ_FREE,  32'h0FFF_F000, 1'b1, '{ST_ALREADY_FREE, 32'h0000_0000, 17'd2}},
    '{REQ_ALLOC, 32'hFFFF_FFFF, 1'b1, '{ST_OK,           32'h0FFF_F000, 17'd1}},
    '{REQ_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK,           32'h0000_0000, 17'd0}},
    '{REQ_ALLOC, 32'h0000_0000, 1'b1, '{ST_EMPTY,        32'h0000_0000, 17'd0}},
    '{REQ_FREE,  32'h0000_1234, 1'b1, '{ST_OK,           32'h0000_0000, 17'd1}},
    '{REQ_FREE,  32'hFFFF_F000, 1'b1, '{ST_RANGE,        32'h0000_0000, 17'd1}},
    '{REQ_FREE,  32'h0000_2000, 1'b0, '{ST_OK,           32'h0000_0000, 17'd0}},
    '{REQ_FREE,  32'h0000_3FFF, 1'b0, '{ST_OK,           32'h0000_0000, 17'd0}},
    '{REQ_ALLOC, 32'h5555_5555, 1'b0, '{ST_OK,           32'h0000_0000, 17'd0}},
    '{REQ_ALLOC, 32'hAAAA_AAAA, 1'b0, '{ST_OK,           32'h0000_0000, 17'd0}},
    '{REQ_FREE,  32'h0FFF_F000, 1'b0, '{ST_OK,           32'h0000_0000, 17'd0}}
  };

  page_frame_allocator #(
    .NUM_FRAMES(NumFrames),
    .PAGE_BYTES(PageBytes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .free_addr_i (free_addr),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .alloc_addr_o(alloc_addr),
    .free_count_o(free_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Allocation pops the top of the free stack; a free of a used frame pushes it.
  task automatic allocate_or_free(input req_e req, input logic [AddrWidth-1:0] addr,
                                  output frame_result_t res);
    logic [AddrWidth-1:0]  frame_no;
    logic [FrameWidth-1:0] frame;
    res.status = ST_OK;
    res.addr   = '0;
    if (req == REQ_ALLOC) begin
      if (stack_depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        stack_depth = stack_depth - 1'b1;
        frame = free_list[stack_depth];
        frame_used[frame] = 1'b1;
        res.addr = AddrWidth'(frame) * PageBytes;
        held_frames.push_back(frame);
      end
    end else begin
      frame_no = addr / PageBytes;
      if (frame_no >= NumFrames) begin
        res.status = ST_RANGE;
      end else begin
        frame = frame_no[FrameWidth-1:0];
        if (!frame_used[frame]) begin
          res.status = ST_ALREADY_FREE;
        end else if (stack_depth < NumFrames) begin
          frame_used[frame] = 1'b0;
          free_list[stack_depth] = frame;
          stack_depth = stack_depth + 1'b1;
        end
      end
    end
    res.count = stack_depth;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sender_quiet || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AddrWidth-1:0] frame_addr(input int unsigned frame);
    return AddrWidth'(frame * PageBytes + $urandom_range(0, PageBytes - 1));
  endfunction

  task automatic send_word(input req_e req, input logic [AddrWidth-1:0] addr,
                           input bit typed, input frame_result_t typed_res);
    frame_result_t res;
    int unsigned   gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    free_addr <= addr;
    do @(posedge clk_i); while (in_stall);
    allocate_or_free(req, addr, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_request(input req_e req, input logic [AddrWidth-1:0] addr);
    send_word(req, addr, 1'b0, no_result);
  endtask

  task automatic send_mixed();
    int unsigned           roll;
    int unsigned           idx;
    logic [FrameWidth-1:0] frame;
    roll = $urandom_range(0, 99);
    if (roll < 38) begin
      send_request(REQ_ALLOC, $urandom());
    end else if (roll < 66 && held_frames.size() != 0) begin
      idx = $urandom_range(0, held_frames.size() - 1);
      frame = held_frames[idx];
      held_frames.delete(idx);
      send_request(REQ_FREE, frame_addr(frame));
    end else if (roll < 76 && stack_depth != 0) begin
      frame = free_list[$urandom_range(0, stack_depth - 1)];
      send_request(REQ_FREE, frame_addr(frame));
    end else if (roll < 88) begin
      send_request(REQ_FREE, frame_addr($urandom_range(0, NumFrames - 1)));
    end else begin
      send_request(REQ_FREE, $urandom());
    end
  endtask

  task automatic send_ascending_frees(input int unsigned num);
    int unsigned base;
    base = $urandom_range(0, NumFrames - 2 * num);
    for (int k = 0; k < num; k++) begin
      send_request(REQ_FREE, frame_addr(base + k * $urandom_range(1, 2)));
    end
  endtask

  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left   = LongHold;
      open_left    = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (open_left != 0) begin
      open_left--;
      out_stall <= 1'b0;
    end else begin
      open_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: status %0d addr %h count %0d",
                   status, alloc_addr, free_count);
        end
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || alloc_addr !== want.addr ||
            free_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d addr %h count %0d, got %0d %h %0d",
                     want.status, want.addr, want.count, status, alloc_addr, free_count);
          end
        end
      end
    end
  end

  initial begin
    for (int f = 0; f < NumFrames; f++) begin
      frame_used[f] = 1'b1;
    end
    stack_depth = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumDirected; r++) begin
      send_word(directed_rows[r].req, directed_rows[r].addr, directed_rows[r].typed,
                directed_rows[r].result);
    end

    send_ascending_frees(40);
    for (int k = 0; k < 140; k++) send_mixed();

    // The receiver holds off while words keep coming, so the block backs up.
    hold_requests <= hold_requests + 1;
    sender_quiet = 1'b1;
    for (int k = 0; k < 30; k++) send_mixed();
    sender_quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (stack_depth != 0) send_request(REQ_ALLOC, $urandom());
    for (int k = 0; k < 3; k++) send_request(REQ_ALLOC, $urandom());

    send_ascending_frees(30);
    for (int k = 0; k < 70; k++) send_mixed();
    sender_quiet = 1'b1;
    for (int k = 0; k < 40; k++) send_mixed();
    sender_quiet = 1'b0;
    for (int k = 0; k < 60; k++) send_mixed();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
